/* src/lmfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_pkg
// Shared types and constants of the load meter frame receiver.
// ----------------------------------------------------------------------------
package lmfr_pkg;

    localparam logic [7:0] BYTE_BEGIN = 8'hFA;
    localparam logic [7:0] BYTE_END   = 8'hF8;
    localparam int unsigned MEAS_LEN  = 19;
    localparam int unsigned NUM_PAIRS = 6;

    localparam logic [7:0] TYPE_IDLE     = 8'h00;
    localparam logic [7:0] TYPE_LIMITS   = 8'h0A;
    localparam logic [7:0] TYPE_OFF      = 8'h64;
    localparam logic [7:0] TYPE_ON       = 8'h6E;

    localparam int unsigned CODE_W    = 16;
    localparam int unsigned M_TDATA_W = 104;
    localparam int unsigned M_TUSER_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLTAGE = 2'd1;

    // pair slots in the captured frame
    localparam int unsigned PAIR_CURRENT   = 0;
    localparam int unsigned PAIR_VOLTAGE   = 1;
    localparam int unsigned PAIR_DPLUS     = 2;
    localparam int unsigned PAIR_DMINUS    = 3;
    localparam int unsigned PAIR_LIMIT     = 4;
    localparam int unsigned PAIR_THRESHOLD = 5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NOT_MEAS = 2'd2,
        ST_BAD_XOR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_TOGGLE = 2'd1,
        ACT_START  = 2'd2,
        ACT_CONFIG = 2'd3
    } action_t;

    typedef struct packed {
        status_t                               status;
        logic                                  load_type;
        logic                                  rep;
        logic [NUM_PAIRS-1:0][CODE_W-1:0]      codes;
    } frame_rec_t;

    typedef struct packed {
        logic [CODE_W-1:0] limit_ma;
        logic [CODE_W-1:0] undervoltage;
    } cfg_t;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

/* src/lmfr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_front
// Byte framing: hunts for the begin byte, tracks length and XOR, decodes
// base-240 pairs on the fly and classifies each finished frame.
// ----------------------------------------------------------------------------
module lmfr_front
    import lmfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       push,
    output frame_rec_t push_rec
);

    localparam int unsigned LW = $clog2(FRAME_MAX + 1);

    logic                              in_frame_reg, in_frame_next;
    logic [LW-1:0]                     len_reg, len_next;
    logic [7:0]                        xor_reg, xor_next;
    logic [7:0]                        type_reg;
    logic [7:0]                        hi_reg;
    logic [NUM_PAIRS-1:0][CODE_W-1:0]  codes_reg;

    logic [LW-1:0]     len_plus;
    logic [LW-1:0]     pos_m3;
    logic [2:0]        pair_idx;
    logic [CODE_W-1:0] hi_x240;
    logic [CODE_W-1:0] pair_code;
    logic              is_begin, is_end, take, lo_slot;
    logic              type_known;

    assign is_begin = (byte_data == BYTE_BEGIN);
    assign is_end   = (byte_data == BYTE_END);
    assign take     = byte_valid && !is_begin && in_frame_reg;
    assign len_plus = len_reg + LW'(1);
    assign pos_m3   = len_reg - LW'(3);
    assign pair_idx = pos_m3[3:1];
    assign lo_slot  = len_reg[0] && (len_reg >= LW'(3)) && (len_reg <= LW'(13));

    // hi * 240 = hi * 256 - hi * 16
    assign hi_x240   = {hi_reg, 8'd0} - {4'd0, hi_reg, 4'd0};
    assign pair_code = hi_x240 + {8'd0, byte_data};

    assign type_known = (type_reg == TYPE_IDLE) || (type_reg == TYPE_LIMITS) ||
                        (type_reg == TYPE_OFF)  || (type_reg == TYPE_ON);

    always_comb begin
        in_frame_next = in_frame_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        if (byte_valid && is_begin) begin
            in_frame_next = 1'b1;
            len_next      = LW'(1);
            xor_next      = 8'd0;
        end else if (take) begin
            if (is_end || (len_plus >= LW'(FRAME_MAX))) begin
                in_frame_next = 1'b0;
                len_next      = '0;
                xor_next      = 8'd0;
            end else begin
                len_next = len_plus;
                xor_next = xor_reg ^ byte_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            xor_reg      <= 8'd0;
        end else begin
            in_frame_reg <= in_frame_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
        end
    end

    // capture type and pair codes by position
    always_ff @(posedge aclk) begin
        if (take) begin
            if (len_reg == LW'(1)) begin
                type_reg <= byte_data;
            end
            if (!len_reg[0]) begin
                hi_reg <= byte_data;
            end
            if (lo_slot) begin
                codes_reg[pair_idx] <= pair_code;
            end
        end
    end

    assign push = take && is_end;

    always_comb begin
        push_rec.load_type = (type_reg == TYPE_LIMITS) || (type_reg == TYPE_ON);
        push_rec.rep       = (type_reg == TYPE_LIMITS);
        push_rec.codes     = codes_reg;
        if (len_plus < LW'(3)) begin
            push_rec.status = ST_SHORT;
        end else if ((len_plus != LW'(MEAS_LEN)) || !type_known) begin
            push_rec.status = ST_NOT_MEAS;
        end else if (xor_reg != 8'd0) begin
            push_rec.status = ST_BAD_XOR;
        end else begin
            push_rec.status = ST_OK;
        end
    end

endmodule

/* src/lmfr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module lmfr_queue
    import lmfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    output logic       pop_valid,
    input  logic       pop,
    output frame_rec_t pop_rec
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_rec   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* src/lmfr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_back
// Result stage: updates the load-on flag, picks the command action and
// holds the result item in an output register.
// ----------------------------------------------------------------------------
module lmfr_back
    import lmfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 rec_valid,
    input  frame_rec_t           rec,
    output logic                 rec_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic                 load_active_reg, load_active_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] data_reg, data_next;
    logic [M_TUSER_W-1:0] user_reg, user_next;

    logic                 ok;
    logic                 load_new;
    logic [CODE_W-1:0]    lim, thr;
    action_t              act;

    assign rec_pop = rec_valid && (!out_valid_reg || m_tready);
    assign ok      = (rec.status == ST_OK);
    assign load_new = ok ? rec.load_type : load_active_reg;
    assign lim     = rec.rep ? rec.codes[PAIR_LIMIT] : '0;
    assign thr     = rec.rep ? rec.codes[PAIR_THRESHOLD] : '0;

    always_comb begin
        priority if (load_new && (cfg.limit_ma == '0)) begin
            act = ACT_TOGGLE;
        end else if (!load_new && (cfg.limit_ma != '0)) begin
            act = ACT_START;
        end else if (load_new && rec.rep &&
                     ((lim != cfg.limit_ma) || (thr != cfg.undervoltage))) begin
            act = ACT_CONFIG;
        end else begin
            act = ACT_NONE;
        end
    end

    always_comb begin
        load_active_next = load_active_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        data_next        = data_reg;
        user_next        = user_reg;
        if (rec_pop) begin
            load_active_next = load_new;
            out_valid_next   = 1'b1;
            user_next        = {ok && rec.rep, rec.status};
            if (ok) begin
                data_next = {5'd0, act, thr, lim,
                             rec.codes[PAIR_DMINUS], rec.codes[PAIR_DPLUS],
                             rec.codes[PAIR_VOLTAGE], rec.codes[PAIR_CURRENT],
                             load_new};
            end else begin
                data_next = {{(M_TDATA_W-1){1'b0}}, load_active_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            load_active_reg <= load_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

/* src/load_meter_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_meter_frame_receiver
// Assembles load meter frames from a byte stream and reports one result
// item per finished frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   : one received byte per item in s_tdata[7:0].
//   m_*   : one result item per frame that ends with the end byte; frames
//           that overflow FRAME_MAX bytes are dropped without a result.
//   cfg_* : register writes, index 0 current limit, 1 under-voltage code;
//           cfg_ready is always high, other indexes are ignored.
// Throughput is one byte per cycle while the queue is not full. After the
// end byte is taken, the classified frame enters the queue and then moves
// into the output register, which raises m_tvalid. Two classified frames
// wait in the queue; when it is full, s_tready drops until the result stage
// frees a slot, which happens when the output register is empty or m_tready
// takes the pending result.
// Reset clears framing, queue, output valid and the load-on flag, and sets
// both configuration registers to zero.
// ----------------------------------------------------------------------------
module load_meter_frame_receiver
    import lmfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] load_on, [16:1] bus_current, [32:17] bus_voltage,
    // [48:33] dplus_voltage, [64:49] dminus_voltage, [80:65] reported_limit,
    // [96:81] reported_threshold, [98:97] action, [103:99] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // [1:0] frame_status, [2] limits_reported
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       q_full, q_valid, q_pop, push;
    frame_rec_t push_rec, pop_rec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_LIMIT_MA) begin
                cfg_next.limit_ma = cfg_data;
            end
            if (cfg_index == CFG_UNDERVOLTAGE) begin
                cfg_next.undervoltage = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lmfr_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .byte_data  (s_tdata),
        .push       (push),
        .push_rec   (push_rec)
    );

    lmfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_rec   (pop_rec)
    );

    lmfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (q_valid),
        .rec       (pop_rec),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* src/lmfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfr_checker
// Port-level checks of the load meter frame receiver result channel.
// ----------------------------------------------------------------------------
module lmfr_checker
    import lmfr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a failed frame carries only the load-on flag
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != ST_OK) |-> (m_tdata[M_TDATA_W-1:1] == '0) &&
        !m_tuser[2])
        else $error("failed frame carries values");

    // reported limits are zero unless flagged
    a_rep_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> (m_tdata[96:65] == '0))
        else $error("reported limits without flag");

    // toggle and config only with load on
    a_action_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[98:97] == ACT_TOGGLE) || (m_tdata[98:97] == ACT_CONFIG))
        |-> m_tdata[0])
        else $error("load action with load off");

endmodule

bind load_meter_frame_receiver lmfr_checker u_lmfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/frame_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte, result and register channels of the frame receiver. It
// keeps its own framing state, predicts one result per finished frame and
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_result_checker
    import lmfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        status_t                          status;
        logic                             load_on;
        logic                             rep;
        action_t                          act;
        logic [NUM_PAIRS-1:0][CODE_W-1:0] codes;
    } frame_result_t;

    logic [7:0]        rx_buf [FRAME_MAX];
    int unsigned       rx_len;
    logic              in_frame;
    logic [7:0]        chk_xor;
    logic              load_active;
    logic [CODE_W-1:0] limit_reg;
    logic [CODE_W-1:0] uv_reg;
    frame_result_t     expected_q [$];

    string pair_name [NUM_PAIRS] = '{"bus_current", "bus_voltage", "dplus_voltage",
                                     "dminus_voltage", "reported_limit",
                                     "reported_threshold"};

    function automatic logic [CODE_W-1:0] pair_at(input int unsigned at);
        logic [31:0] v;
        v = rx_buf[at] * 240 + rx_buf[at + 1];
        return v[CODE_W-1:0];
    endfunction

    function automatic frame_result_t close_frame();
        frame_result_t r;
        logic [7:0]    kind;
        r = '0;
        r.load_on = load_active;
        if (rx_len < 3) begin
            r.status = ST_SHORT;
            return r;
        end
        kind = rx_buf[1];
        if (rx_len != MEAS_LEN || !(kind == TYPE_IDLE || kind == TYPE_LIMITS ||
                                    kind == TYPE_OFF || kind == TYPE_ON)) begin
            r.status = ST_NOT_MEAS;
            return r;
        end
        if (chk_xor != 8'h00) begin
            r.status = ST_BAD_XOR;
            return r;
        end
        load_active = (kind == TYPE_LIMITS || kind == TYPE_ON);
        r.load_on = load_active;
        r.rep = (kind == TYPE_LIMITS);
        for (int k = PAIR_CURRENT; k <= PAIR_DMINUS; k++) begin
            r.codes[k] = pair_at(2 + 2 * k);
        end
        if (r.rep) begin
            r.codes[PAIR_LIMIT]     = pair_at(10);
            r.codes[PAIR_THRESHOLD] = pair_at(12);
        end
        if (load_active && limit_reg == '0) begin
            r.act = ACT_TOGGLE;
        end else if (!load_active && limit_reg != '0) begin
            r.act = ACT_START;
        end else if (load_active && r.rep && (r.codes[PAIR_LIMIT] != limit_reg ||
                                              r.codes[PAIR_THRESHOLD] != uv_reg)) begin
            r.act = ACT_CONFIG;
        end else begin
            r.act = ACT_NONE;
        end
        return r;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        // a begin byte always restarts, even in the middle of a frame
        if (b == BYTE_BEGIN) begin
            rx_buf[0] = b;
            rx_len    = 1;
            chk_xor   = 8'h00;
            in_frame  = 1'b1;
            return;
        end
        if (!in_frame) begin
            return;
        end
        rx_buf[rx_len] = b;
        rx_len++;
        if (b == BYTE_END) begin
            expected_q.push_back(close_frame());
            in_frame = 1'b0;
            rx_len   = 0;
            chk_xor  = 8'h00;
            return;
        end
        chk_xor ^= b;
        // drop a frame that fills the buffer without an end byte
        if (rx_len >= FRAME_MAX) begin
            in_frame = 1'b0;
            rx_len   = 0;
            chk_xor  = 8'h00;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result();
        frame_result_t     want;
        logic [CODE_W-1:0] got_code;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result item with no frame pending, tuser %0h",
                                      m_tuser));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (m_tuser[1:0] !== want.status) begin
            report_mismatch($sformatf("frame_status got %0d, expected %0d",
                                      m_tuser[1:0], want.status));
        end
        if (m_tuser[2] !== want.rep) begin
            report_mismatch($sformatf("limits_reported got %0b, expected %0b",
                                      m_tuser[2], want.rep));
        end
        if (m_tdata[0] !== want.load_on) begin
            report_mismatch($sformatf("load_on got %0b, expected %0b",
                                      m_tdata[0], want.load_on));
        end
        for (int k = 0; k < NUM_PAIRS; k++) begin
            got_code = m_tdata[1 + CODE_W * k +: CODE_W];
            if (got_code !== want.codes[k]) begin
                report_mismatch($sformatf("%s got %0d, expected %0d", pair_name[k],
                                          got_code, want.codes[k]));
            end
        end
        if (m_tdata[98:97] !== want.act) begin
            report_mismatch($sformatf("action got %0d, expected %0d",
                                      m_tdata[98:97], want.act));
        end
        if (m_tdata[M_TDATA_W-1:99] !== '0) begin
            report_mismatch($sformatf("padding bits got %0h, expected 0",
                                      m_tdata[M_TDATA_W-1:99]));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_len      = 0;
            in_frame    = 1'b0;
            chk_xor     = 8'h00;
            load_active = 1'b0;
            limit_reg   = '0;
            uv_reg      = '0;
            mismatches  = 0;
            checked     = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LIMIT_MA:     limit_reg = cfg_data;
                    CFG_UNDERVOLTAGE: uv_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        pending = expected_q.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the load meter frame receiver: a directed set of
// frames for the framing and decoding corner cases, then random frames and
// noise under several register settings, with idle bursts on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import lmfr_pkg::*;

    localparam int unsigned FRAME_MAX      = 32;
    localparam int unsigned CLK_HALF       = 5;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned LINGER         = 12;
    localparam int unsigned TARGET_BYTES   = 750;
    localparam int unsigned QUIET_AFTER    = 600;
    localparam longint     TIMEOUT_NS      = 4_000_000;

    localparam logic [CODE_W-1:0]    CODE_MAX     = 16'd61439;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam logic [7:0]           TYPE_UNKNOWN = 8'h01;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data  = '0;

    int mismatches;
    int pending;
    int checked;

    int                idle_rate = 2;
    int unsigned       frame_bytes_sent;
    int unsigned       frames_sent;
    int unsigned       frames_dropped;
    int unsigned       cfg_writes;
    logic [CODE_W-1:0] cur_limit = '0;
    logic [CODE_W-1:0] cur_uv    = '0;
    logic [7:0]        frame_q [$];

    always #(CLK_HALF) aclk = ~aclk;

    load_meter_frame_receiver #(
        .FRAME_MAX (FRAME_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_result_checker #(
        .FRAME_MAX (FRAME_MAX)
    ) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // result side: stall in short bursts while idling is enabled
    initial begin
        forever begin
            if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate * 8) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == BYTE_BEGIN || v == BYTE_END);
        return v;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CODE_MAX;
            2: return 16'd1;
            default: return CODE_W'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    // measurement frame; payload avoids the begin and end bytes
    function automatic void build_meas(input logic [7:0] kind, input bit corrupt,
                                       input bit echo, input int fill);
        logic [7:0] p [18];
        logic [7:0] x;
        logic [7:0] c;
        p[1] = kind;
        for (int i = 2; i <= 16; i++) begin
            if (fill == FILL_ZERO) begin
                p[i] = 8'h00;
            end else if (fill == FILL_ONES) begin
                p[i] = 8'hFF;
            end else begin
                p[i] = body_byte();
            end
        end
        // echo the programmed limit and threshold where they encode cleanly
        if (echo && (cur_limit / 240) != BYTE_BEGIN && (cur_limit / 240) != BYTE_END) begin
            p[10] = 8'(cur_limit / 240);
            p[11] = 8'(cur_limit % 240);
        end
        if (echo && (cur_uv / 240) != BYTE_BEGIN && (cur_uv / 240) != BYTE_END) begin
            p[12] = 8'(cur_uv / 240);
            p[13] = 8'(cur_uv % 240);
        end
        x = 8'h00;
        for (int i = 1; i <= 16; i++) begin
            x ^= p[i];
        end
        while (x == BYTE_BEGIN || x == BYTE_END) begin
            x ^= p[16];
            p[16] = body_byte();
            x ^= p[16];
        end
        if (corrupt) begin
            do begin
                c = body_byte();
            end while (c == x);
            x = c;
        end
        p[17] = x;
        frame_q.delete();
        frame_q.push_back(BYTE_BEGIN);
        for (int i = 1; i <= 17; i++) begin
            frame_q.push_back(p[i]);
        end
        frame_q.push_back(BYTE_END);
    endfunction

    function automatic void build_run(input int unsigned n, input bit closed);
        frame_q.delete();
        frame_q.push_back(BYTE_BEGIN);
        repeat (n) frame_q.push_back(body_byte());
        if (closed) begin
            frame_q.push_back(BYTE_END);
        end
    endfunction

    // entered and left at a falling edge; valid stays high between items unless an idle burst is drawn
    task automatic push_byte(input logic [7:0] b);
        if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate * 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            push_byte(frame_q[i]);
        end
        frame_bytes_sent += frame_q.size();
        frames_sent++;
    endtask

    // hold the byte stream until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (LINGER) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == CFG_LIMIT_MA) begin
            cur_limit = val;
        end else if (idx == CFG_UNDERVOLTAGE) begin
            cur_uv = val;
        end
        cfg_writes++;
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still pending", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [7:0] kinds [4];
        logic [7:0] kind;
        int         pick;
        kinds = '{TYPE_IDLE, TYPE_LIMITS, TYPE_OFF, TYPE_ON};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // noise while hunting, then short and odd frames
        push_byte(8'h00);
        push_byte(BYTE_END);
        push_byte(8'hFF);
        push_byte(8'h7F);
        build_run(0, 1'b1);
        send_frame();
        build_run(1, 1'b1);
        send_frame();
        // all four kinds, two of them at the fill extremes, wrong kind, bad check
        build_meas(TYPE_IDLE, 1'b0, 1'b0, FILL_ZERO);
        send_frame();
        build_meas(TYPE_ON, 1'b0, 1'b0, FILL_ONES);
        send_frame();
        build_meas(TYPE_LIMITS, 1'b0, 1'b1, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_UNKNOWN, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_OFF, 1'b1, 1'b0, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_OFF, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();
        // begin byte inside a frame restarts it
        build_run(3, 1'b0);
        send_frame();
        build_meas(TYPE_ON, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();
        // overflow drops the frame; the stray end byte is then ignored
        build_run(FRAME_MAX - 1, 1'b0);
        send_frame();
        frames_dropped++;
        push_byte(BYTE_END);
        build_run(FRAME_MAX - 2, 1'b1);
        send_frame();

        settle();
        write_reg(CFG_LIMIT_MA, CODE_MAX);
        write_reg(CFG_UNDERVOLTAGE, CODE_MAX);
        write_reg(CFG_SPARE, '1);
        build_meas(TYPE_IDLE, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_LIMITS, 1'b0, 1'b1, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_LIMITS, 1'b0, 1'b0, FILL_ONES);
        send_frame();
        build_meas(TYPE_ON, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();

        settle();
        write_reg(CFG_LIMIT_MA, 16'd1);
        write_reg(CFG_UNDERVOLTAGE, '0);
        build_meas(TYPE_LIMITS, 1'b0, 1'b1, FILL_RANDOM);
        send_frame();
        build_meas(TYPE_OFF, 1'b0, 1'b0, FILL_RANDOM);
        send_frame();

        while (frame_bytes_sent < TARGET_BYTES) begin
            idle_rate = (frame_bytes_sent > QUIET_AFTER) ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 14) == 0) begin
                settle();
                write_reg(CFG_LIMIT_MA, pick_code());
                write_reg(CFG_UNDERVOLTAGE, pick_code());
            end
            kind = kinds[$urandom_range(0, 3)];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                build_meas(kind, 1'b0, $urandom_range(0, 9) < 3,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : FILL_RANDOM);
                send_frame();
            end else if (pick < 70) begin
                build_meas(kind, 1'b1, 1'b0, FILL_RANDOM);
                send_frame();
            end else if (pick < 75) begin
                do begin
                    kind = body_byte();
                end while (kind == TYPE_IDLE || kind == TYPE_LIMITS ||
                           kind == TYPE_OFF || kind == TYPE_ON);
                build_meas(kind, 1'b0, 1'b0, FILL_RANDOM);
                send_frame();
            end else if (pick < 83) begin
                build_run($urandom_range(0, FRAME_MAX - 2), 1'b1);
                send_frame();
            end else if (pick < 87) begin
                build_run(FRAME_MAX - 1, 1'b0);
                send_frame();
                frames_dropped++;
            end else if (pick < 92) begin
                build_run($urandom_range(1, 20), 1'b0);
                send_frame();
                build_meas(kind, 1'b0, 1'b1, FILL_RANDOM);
                send_frame();
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 6)) begin
                    do begin
                        kind = 8'($urandom_range(0, 255));
                    end while (kind == BYTE_BEGIN);
                    push_byte(kind);
                end
            end else begin
                settle();
            end
        end

        idle_rate = 0;
        settle();
        $display("Sent %0d frame bytes in %0d frames (%0d overflowed), %0d register writes",
                 frame_bytes_sent, frames_sent, frames_dropped, cfg_writes);
        $display("Compared %0d result items with prediction, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/lmfr_pkg.sv
src/lmfr_front.sv
src/lmfr_queue.sv
src/lmfr_back.sv
src/load_meter_frame_receiver.sv
src/lmfr_checker.sv
dv/frame_result_checker.sv
dv/testbench.sv
